/* rtl/wf3_pkg.sv */
// Shared types, constants and reduction functions for the 3x3 window filter.
package wf3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 24;
    localparam int LB_W      = 2 * PIX_W;

    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [1:0]         MODE_RESET   = 2'd0;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd768;

    // reciprocal of 3 in Q11, exact for sums up to 765
    localparam logic [19:0] RECIP3 = 20'd683;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [LB_W-1:0]  data;
    } lb_wr_t;

    typedef struct packed {
        logic pr0;      // row above is finished
        logic pr1;      // current row is the frame's last
        logic pc0;      // column to the left is finished
        logic pc1;      // current column is the row's last
        logic interior;
    } emit_flags_t;

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * RECIP3;
        return p[18:11];
    endfunction

    // mode bit 1 selects maximum (also for code three), bit 0 minimum
    function automatic logic [7:0] reduce3(input logic [1:0] mode,
                                           input logic [7:0] x,
                                           input logic [7:0] y,
                                           input logic [7:0] z);
        logic [7:0] m;
        logic [9:0] s;
        m = 8'd0;
        s = 10'(x) + 10'(y) + 10'(z);
        if (mode[1]) begin
            m = (x > y) ? x : y;
            m = (m > z) ? m : z;
        end else if (mode[0]) begin
            m = (x < y) ? x : y;
            m = (m < z) ? m : z;
        end else begin
            m = div3(s);
        end
        return m;
    endfunction

    function automatic pix_t reduce_pix(input logic [1:0] mode,
                                        input pix_t a,
                                        input pix_t b,
                                        input pix_t c);
        pix_t r;
        r = '0;
        for (int ch = 0; ch < 3; ch++) begin
            r[8*ch +: 8] = reduce3(mode, a[8*ch +: 8], b[8*ch +: 8], c[8*ch +: 8]);
        end
        return r;
    endfunction

endpackage

/* rtl/window_filter_3x3_core.sv */
// Top level of the streaming 3x3 average / minimum / maximum filter on BGR pixels.
//
//  channel   direction  transfer when          payload
//  s_*       in         s_tvalid & s_tready    s_tdata: pix_b, pix_g, pix_r
//  m_*       out        m_tvalid & m_tready    m_tdata: out_b, out_g, out_r;
//                                              m_tlast: run_last; m_tuser: frame_end
//  cfg_*     in         cfg_wr_en              cfg_index selects register, cfg_wdata
//
// One pixel per clock while m_tready does not stall. An accepted pixel passes the line
// store read, the row reduction and the output register in turn. A pixel that completes
// two or four neighborhoods (last column, last row) holds the input while the emit
// stage drains its outputs, one per cycle while m_tready is high.
// Reset is synchronous, active low: it empties the pipeline, zeroes the window and
// counters and restores the register defaults; the line store is not cleared.
// A stalled m_tready holds the output register and back-pressures through the
// pipeline to s_tready.
module window_filter_3x3_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // pix_b, pix_g, pix_r
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // out_b, out_g, out_r
    output logic                             m_tlast,   // run_last
    output logic                             m_tuser,   // frame_end
    input  logic                             cfg_wr_en,
    input  logic [wf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wf3_pkg::CFG_W-1:0]        cfg_wdata
);
    import wf3_pkg::*;

    // configuration, stored already saturated to legal geometry
    logic [1:0]         mode_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [IMG_W_W-1:0] width_next;

    // raster counters
    logic [IMG_H_W-1:0] row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               last_col;
    logic               last_row;
    emit_flags_t        flags_in;

    // stage 1: line store read in flight
    logic               v1_reg;
    pix_t               px1_reg;
    logic [COL_W-1:0]   c1_reg;
    emit_flags_t        f1_reg;

    // window: row 0 two above, row 1 above, row 2 current; column 2 newest
    pix_t               win_reg [3][3];
    pix_t               win_next [3][3];
    logic [LB_W-1:0]    lb_rd;
    lb_wr_t             lb_wr;

    // stage 2: row results and border candidates, drained by the emit logic
    logic [3:0]         pend_reg;
    logic               int2_reg;
    pix_t               rr_reg [3];
    pix_t               bp_reg [4];

    // output register
    logic               m_valid_reg;
    pix_t               m_data_reg;
    logic               m_last_reg;
    logic               m_user_reg;

    logic               in_fire;
    logic               out_free;
    logic               emit;
    logic               s2_done;
    logic               adv1;
    logic [1:0]         sel;
    logic [3:0]         sel_bit;
    logic [3:0]         pend_left;
    pix_t               col_res;
    pix_t               emit_pix;

    // ---------------- configuration ----------------
    always_comb begin
        width_next = cfg_wdata[IMG_W_W-1:0];
        if (width_next == '0) begin
            width_next = IMG_W_W'(1);
        end else if (width_next > IMG_W_W'(MAX_WIDTH)) begin
            width_next = IMG_W_W'(MAX_WIDTH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FILTER_MODE:  mode_reg   <= cfg_wdata[1:0];
                REG_IMAGE_WIDTH:  width_reg  <= width_next;
                REG_IMAGE_HEIGHT: height_reg <= (cfg_wdata == '0) ? IMG_H_W'(1) : cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (pend_reg != '0) && out_free;
    assign s2_done  = emit && (pend_left == '0);
    assign adv1     = v1_reg && ((pend_reg == '0) || s2_done);
    assign s_tready = !v1_reg || adv1;
    assign in_fire  = s_tvalid && s_tready;

    // ---------------- stage 0: position of the incoming pixel ----------------
    assign last_col = {1'b0, col_reg} == (width_reg - IMG_W_W'(1));
    assign last_row = row_reg == (height_reg - IMG_H_W'(1));

    always_comb begin
        flags_in.pr0      = row_reg != '0;
        flags_in.pr1      = last_row;
        flags_in.pc0      = col_reg != '0;
        flags_in.pc1      = last_col;
        // output pixel one up and one left is interior
        flags_in.interior = (width_reg >= IMG_W_W'(3)) && (height_reg >= IMG_H_W'(3)) &&
                            (row_reg >= IMG_H_W'(2)) && (col_reg >= COL_W'(2));
    end

    // geometry writes restart the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (cfg_wr_en &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (in_fire) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + IMG_H_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_fire) begin
            v1_reg <= 1'b1;
        end else if (adv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            px1_reg <= s_tdata;
            c1_reg  <= col_reg;
            f1_reg  <= flags_in;
        end
    end

    // entry holds {two above, above}; shift it down one row as the pixel retires
    always_comb begin
        lb_wr.en   = adv1;
        lb_wr.addr = c1_reg;
        lb_wr.data = {lb_rd[PIX_W-1:0], px1_reg};
    end

    wf3_line_buf u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .wr      (lb_wr),
        .rd_data (lb_rd)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k][0] = win_reg[k][1];
            win_next[k][1] = win_reg[k][2];
        end
        win_next[0][2] = lb_rd[LB_W-1:PIX_W];
        win_next[1][2] = lb_rd[PIX_W-1:0];
        win_next[2][2] = px1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[k][j] <= '0;
                end
            end
        end else if (adv1) begin
            win_reg <= win_next;
        end
    end

    // ---------------- stage 2: row results and emit list ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (adv1) begin
            pend_reg <= {f1_reg.pr1 & f1_reg.pc1, f1_reg.pr1 & f1_reg.pc0,
                         f1_reg.pr0 & f1_reg.pc1, f1_reg.pr0 & f1_reg.pc0};
        end else if (emit) begin
            pend_reg <= pend_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            int2_reg <= f1_reg.interior;
            for (int k = 0; k < 3; k++) begin
                rr_reg[k] <= reduce_pix(mode_reg, win_next[k][0], win_next[k][1],
                                        win_next[k][2]);
            end
            // border copies: above-left, above, left, current
            bp_reg[0] <= win_next[1][1];
            bp_reg[1] <= win_next[1][2];
            bp_reg[2] <= win_next[2][1];
            bp_reg[3] <= win_next[2][2];
        end
    end

    // drain outputs in raster order: lowest pending bit first
    always_comb begin
        sel = 2'd3;
        if (pend_reg[0]) begin
            sel = 2'd0;
        end else if (pend_reg[1]) begin
            sel = 2'd1;
        end else if (pend_reg[2]) begin
            sel = 2'd2;
        end
        sel_bit   = 4'b0001 << sel;
        pend_left = pend_reg & ~sel_bit;
    end

    assign col_res  = reduce_pix(mode_reg, rr_reg[0], rr_reg[1], rr_reg[2]);
    assign emit_pix = (sel == 2'd0 && int2_reg) ? col_res : bp_reg[sel];

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= emit_pix;
            m_last_reg <= pend_left == '0;
            // only the current pixel of the last row and column ends the frame
            m_user_reg <= sel == 2'd3;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* rtl/wf3_line_buf.sv */
// Two-row line store: one 48-bit entry per column, registered read with write bypass.
module wf3_line_buf (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [wf3_pkg::COL_W-1:0]    rd_addr,
    input  wf3_pkg::lb_wr_t              wr,
    output logic [wf3_pkg::LB_W-1:0]     rd_data
);
    import wf3_pkg::*;

    logic [LB_W-1:0] mem [MAX_WIDTH];
    logic [LB_W-1:0] rd_q_reg;
    logic [LB_W-1:0] byp_data_reg;
    logic            byp_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr.data;
        end
    end

    // same-address write in the read cycle: take the new data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (rd_en) begin
            byp_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_q_reg;

endmodule

/* rtl/wf3_checker.sv */
// Port-level checks for the 3x3 window filter, bound to the top level.
module wf3_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [23:0]                    m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // frame's last pixel always closes its run
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without run end");

    // a run continues without a gap once its first pixel is taken
    a_run_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an output run");

    // stalled output holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser))
        else $error("stalled output changed");

endmodule

bind window_filter_3x3_core wf3_checker u_wf3_checker (.*);

/* sim/tb_window_filter_3x3_core.sv */
// Self-checking testbench for the streaming 3x3 average / minimum / maximum window filter.
`timescale 1ns / 1ps

module tb_window_filter_3x3_core;
    import wf3_pkg::*;

    // filter_mode codes; code three behaves as maximum
    localparam logic [1:0] MODE_AVG     = 2'd0;
    localparam logic [1:0] MODE_MIN     = 2'd1;
    localparam logic [1:0] MODE_MAX     = 2'd2;
    localparam logic [1:0] MODE_MAX_ALT = 2'd3;

    localparam int PIXEL_TARGET = 195;     // last phase runs past this
    localparam int HOLD_CYCLES  = 400;     // long output stall that backs up the pipeline
    localparam int SETTLE       = 8;       // cycles past the last output before a register write

    // one filtered output pixel as it should appear on the m_ channel
    typedef struct {
        pix_t pix;
        logic run_last;
        logic frame_end;
    } filtered_pix_t;

    // Scoreboard: mirrors line stores, window and counters, and queues the
    // filtered pixels that each accepted input makes due.
    class filter_scoreboard;
        pix_t          upper_row  [MAX_WIDTH];
        pix_t          middle_row [MAX_WIDTH];
        pix_t          win        [3][3];   // [two above, above, current][c-2, c-1, c]
        int unsigned   row_idx;
        int unsigned   col_idx;
        logic [1:0]    mode;
        logic [10:0]   width_reg;
        logic [15:0]   height_reg;
        filtered_pix_t filtered_due [$];
        int            errors;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[k, j]) win[k][j] = '0;
            row_idx    = 0;
            col_idx    = 0;
            mode       = MODE_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
        endfunction

        // geometry writes restart the frame
        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FILTER_MODE: mode = val[1:0];
                REG_IMAGE_WIDTH: begin
                    width_reg = val[10:0];
                    row_idx   = 0;
                    col_idx   = 0;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = val[15:0];
                    row_idx    = 0;
                    col_idx    = 0;
                end
                default: ;
            endcase
        endfunction

        function logic [7:0] reduce_trio(logic [7:0] x, logic [7:0] y, logic [7:0] z);
            logic [9:0] sum;
            logic [7:0] m;
            sum = 10'(x) + 10'(y) + 10'(z);
            if (mode == MODE_AVG) begin
                m = 8'(sum / 10'd3);
            end else if (mode == MODE_MIN) begin
                m = (x < y) ? x : y;
                m = (m < z) ? m : z;
            end else begin
                m = (x > y) ? x : y;
                m = (m > z) ? m : z;
            end
            return m;
        endfunction

        // rows first, then the three row results
        function pix_t window_value();
            pix_t       res;
            logic [7:0] rr [3];
            res = '0;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 3; k++) begin
                    rr[k] = reduce_trio(win[k][0][8*ch +: 8], win[k][1][8*ch +: 8],
                                        win[k][2][8*ch +: 8]);
                end
                res[8*ch +: 8] = reduce_trio(rr[0], rr[1], rr[2]);
            end
            return res;
        endfunction

        function void note_pixel(pix_t px);
            int unsigned   w, h, r, c, npr, npc, pr, pc, wr, wc;
            int unsigned   prs [2];
            int unsigned   pcs [2];
            pix_t          up, mid;
            bit            interior;
            filtered_pix_t item;
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            r = row_idx;
            c = col_idx;
            if (c >= w) c = 0;
            if (r >= h) r = 0;

            up            = upper_row[c];
            mid           = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = px;
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = px;

            // rows and columns whose neighborhoods this pixel completes
            npr = 0;
            npc = 0;
            if (r >= 1) begin
                prs[npr] = r - 1;
                npr++;
            end
            if (r == h - 1) begin
                prs[npr] = r;
                npr++;
            end
            if (c >= 1) begin
                pcs[npc] = c - 1;
                npc++;
            end
            if (c == w - 1) begin
                pcs[npc] = c;
                npc++;
            end

            for (int i = 0; i < npr; i++) begin
                for (int j = 0; j < npc; j++) begin
                    pr       = prs[i];
                    pc       = pcs[j];
                    wr       = (pr == r) ? 2 : 1;
                    wc       = (pc == c) ? 2 : 1;
                    interior = w >= 3 && h >= 3 && pr >= 1 && pr <= h - 2 &&
                               pc >= 1 && pc <= w - 2;
                    item.pix       = interior ? window_value() : win[wr][wc];
                    item.run_last  = (i == npr - 1) && (j == npc - 1);
                    item.frame_end = (pr == h - 1) && (pc == w - 1);
                    filtered_due.push_back(item);
                end
            end

            if (c + 1 >= w) begin
                col_idx = 0;
                row_idx = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_idx = c + 1;
                row_idx = r;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [23:0] data, logic last, logic fend);
            filtered_pix_t want;
            if (filtered_due.size() == 0) begin
                $error("output pixel %h with nothing due", data);
                errors++;
                return;
            end
            want = filtered_due.pop_front();
            compare_field("out_b", want.pix[7:0], data[7:0]);
            compare_field("out_g", want.pix[15:8], data[15:8]);
            compare_field("out_r", want.pix[23:16], data[23:16]);
            compare_field("run_last", want.run_last, last);
            compare_field("frame_end", want.frame_end, fend);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;     // pix_b, pix_g, pix_r
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;     // out_b, out_g, out_r
    logic                 m_tlast;     // run_last
    logic                 m_tuser;     // frame_end
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    filter_scoreboard sb;
    int               pixels_sent;
    bit               calm;            // both sides stop idling while set
    bit               hold_req;        // stimulus asks for the long output stall
    bit               hold_done;

    window_filter_3x3_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // random pixel, each channel pushed to an extreme now and then
    function automatic pix_t random_pixel();
        pix_t p;
        p = pix_t'($urandom());
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(0, 9))
                0:       p[8*ch +: 8] = 8'h00;
                1:       p[8*ch +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return p;
    endfunction

    // Offer one pixel from the falling edge on; idle at random first, then hold
    // tvalid until a transfer happens.
    task automatic send_pixel(input pix_t px);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
        pixels_sent++;
        calm = (pixels_sent >= 150) && (pixels_sent < 200);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    // Drop tvalid, wait for every due pixel, then let the pipeline settle so
    // that a register write finds the block idle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.filtered_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_frame(input logic [1:0] mode, input logic [15:0] w,
                                 input logic [15:0] h);
        program_reg(REG_FILTER_MODE, CFG_W'(mode));
        program_reg(REG_IMAGE_WIDTH, w);
        program_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // Accept results at every rising edge where both tvalid and tready are high.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast, m_tuser);
    end

    // Receiver: random tready at the falling edge, one long hold-off on request.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        pix_t        edge_px [9];
        logic [1:0]  mode_pick;
        logic [15:0] w_val, h_val;
        int unsigned ew, eh, shape, count;
        bit          squeeze, open_ended;

        edge_px = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
                    24'h0000FF, 24'hFFFF00, 24'h000000, 24'hFFFFFF};
        sb          = new();
        pixels_sent = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_FILTER_MODE;
        cfg_wdata   = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Smallest frame with an interior pixel, average of extreme values.
        program_frame(MODE_AVG, 16'd3, 16'd3);
        foreach (edge_px[i]) send_pixel(edge_px[i]);
        drain();

        // Same frame reversed, minimum.
        program_frame(MODE_MIN, 16'd3, 16'd3);
        for (int i = 8; i >= 0; i--) send_pixel(edge_px[i]);
        drain();

        // Width one: every pixel is a border and is copied.
        program_frame(MODE_MAX, 16'd1, 16'd2);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        drain();

        // Code three acts as maximum; height one copies the row.
        program_frame(MODE_MAX_ALT, 16'd2, 16'd1);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        drain();

        // Zero width and zero height both act as one.
        program_frame(MODE_AVG, 16'd0, 16'd0);
        send_pixel(24'h5A5AA5);
        drain();

        // Width above the maximum saturates; frame is cut short by the next write.
        program_frame(MODE_MIN, 16'd2047, 16'd1);
        send_pixel(24'hA5A55A);
        send_pixel(24'h010203);
        drain();

        // Random phases: mostly whole frames, some cut short, some with odd geometry.
        while (pixels_sent < PIXEL_TARGET) begin
            mode_pick  = 2'($urandom_range(0, 3));
            shape      = $urandom_range(0, 99);
            squeeze    = !hold_req && pixels_sent >= 100;
            open_ended = 1'b0;
            if (squeeze) begin
                w_val = 16'd6;
                h_val = 16'd6;
            end else if (shape < 70) begin
                w_val = 16'($urandom_range(3, 7));
                h_val = 16'($urandom_range(3, 6));
            end else if (shape < 82) begin
                w_val = 16'($urandom_range(1, 4));
                h_val = 16'($urandom_range(1, 2));
            end else if (shape < 91) begin
                w_val      = 16'($urandom_range(3, 5));
                h_val      = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1000, 65534));
                open_ended = 1'b1;
            end else begin
                w_val      = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1025, 2047));
                h_val      = 16'($urandom_range(0, 2));
                open_ended = w_val != 0;
            end
            ew = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
            eh = (h_val == 0) ? 1 : h_val;

            if (open_ended) begin
                count = $urandom_range(4, 16);
            end else begin
                // back-to-back frames exercise the counter wrap
                count = ew * eh * $urandom_range(1, 2);
                if (!squeeze && count > 1 && $urandom_range(0, 99) < 15)
                    count = $urandom_range(1, count - 1);
            end

            program_frame(mode_pick, w_val, h_val);
            // stall the output long enough for the block to back up its input
            if (squeeze) hold_req = 1'b1;
            send_random(count);
            drain();
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
